// File: design/ccfu_pkg.sv
`default_nettype none

package ccfu_pkg;

  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 3 * DATA_W;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 8;
  localparam int FLAG_W      = 5;

  typedef enum logic [2:0] {
    OP_LOGIC = 3'd0,
    OP_ADD32 = 3'd1,
    OP_SUB32 = 3'd2,
    OP_ADD   = 3'd3,
    OP_ADDX  = 3'd4,
    OP_SUBX  = 3'd5,
    OP_SUB   = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2
  } size_t;

  typedef struct packed {
    op_t               op;
    size_t             size;
    logic [DATA_W-1:0] result;
    logic [DATA_W-1:0] dest;
    logic [DATA_W-1:0] source;
  } item_t;

  // x in the lowest bit, c in the highest
  typedef struct packed {
    logic c;
    logic v;
    logic z;
    logic n;
    logic x;
  } flags_t;

endpackage

`default_nettype wire

// File: design/ccfu_in_reg.sv
`default_nettype none

module ccfu_in_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ccfu_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [ccfu_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                adv,
  output logic                                item_valid,
  output ccfu_pkg::item_t                     item
);
  import ccfu_pkg::*;

  logic  valid_r;
  item_t item_r;
  item_t item_nxt;

  assign in_tready  = !valid_r || adv;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt.op     = op_t'(in_tuser[2:0]);
    item_nxt.size   = size_t'(in_tuser[4:3]);
    item_nxt.result = in_tdata[DATA_W-1:0];
    item_nxt.dest   = in_tdata[2*DATA_W-1:DATA_W];
    item_nxt.source = in_tdata[3*DATA_W-1:2*DATA_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/ccfu_flag_calc.sv
`default_nettype none

module ccfu_flag_calc (
  input  ccfu_pkg::item_t  item,
  input  ccfu_pkg::flags_t flags_cur,
  output ccfu_pkg::flags_t flags_nxt
);
  import ccfu_pkg::*;

  function automatic logic top_bit(input logic [DATA_W-1:0] w, input size_t sz);
    logic b;
    case (sz)
      SZ_BYTE: b = w[7];
      SZ_WORD: b = w[15];
      default: b = w[DATA_W-1];
    endcase
    return b;
  endfunction

  size_t             eff_size;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] add_c_w, add_v_w, sub_c_w, sub_v_w;
  logic              known, is_sub, is_ext, sets_x, is_logic;
  logic              n, z, v, c;

  always_comb begin
    known    = 1'b1;
    is_sub   = 1'b0;
    is_ext   = 1'b0;
    sets_x   = 1'b0;
    is_logic = 1'b0;
    eff_size = item.size;
    case (item.op)
      OP_LOGIC: is_logic = 1'b1;
      OP_ADD32: eff_size = SZ_LONG;
      OP_SUB32: begin
        eff_size = SZ_LONG;
        is_sub   = 1'b1;
      end
      OP_ADD:   sets_x = 1'b1;
      OP_ADDX: begin
        sets_x = 1'b1;
        is_ext = 1'b1;
      end
      OP_SUBX: begin
        sets_x = 1'b1;
        is_ext = 1'b1;
        is_sub = 1'b1;
      end
      OP_SUB: begin
        sets_x = 1'b1;
        is_sub = 1'b1;
      end
      default:  known = 1'b0;
    endcase

    case (eff_size)
      SZ_BYTE: mask = 32'h0000_00FF;
      SZ_WORD: mask = 32'h0000_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase

    add_c_w = (item.source & item.dest) | (~item.result & (item.source | item.dest));
    add_v_w = ~(item.source ^ item.dest) & (item.result ^ item.dest);
    sub_c_w = (item.source & ~item.dest) | (item.result & ~item.dest)
            | (item.source & item.result);
    sub_v_w = (item.source ^ item.dest) & (item.result ^ item.dest);

    n = top_bit(item.result, eff_size);
    z = ((item.result & mask) == '0);
    if (is_logic) begin
      v = 1'b0;
      c = 1'b0;
    end else if (is_sub) begin
      v = top_bit(sub_v_w, eff_size);
      c = top_bit(sub_c_w, eff_size);
    end else begin
      v = top_bit(add_v_w, eff_size);
      c = top_bit(add_c_w, eff_size);
    end

    flags_nxt = flags_cur;
    if (known) begin
      flags_nxt.n = n;
      flags_nxt.v = v;
      flags_nxt.c = c;
      // extended forms can only clear z, so multi-word zero tests chain
      if (is_ext) begin
        if (!z) begin
          flags_nxt.z = 1'b0;
        end
      end else begin
        flags_nxt.z = z;
      end
      if (sets_x) begin
        flags_nxt.x = c;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/condition_code_flag_unit.sv
// condition_code_flag_unit
// Keeps the X, N, Z, V and C condition flags, updates them per ALU operation
// word (an unused op code keeps them) and returns them as one output word.
// Input channel: in_tuser carries the operation kind and operand size,
// in_tdata the result, destination and source values.
// Output channel: out_tdata carries the five flags after that operation.
// Throughput: one word per cycle while the receiver is ready. The flags are
// read from the flag register, updated combinationally from the input register
// and written back, so one operation can follow the next without a gap.
// An accepted word passes through the input register and then the flag
// register, which drives out_tdata and whose valid bit drives out_tvalid.
// Reset (rst_n low, synchronous) clears all five flags and empties both
// register stages.
// When the receiver stalls, the flag word holds and one more operation is
// taken into the input register; further words wait until the output moves.
`default_nettype none

module condition_code_flag_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // result_value [31:0], dest_operand [63:32], source_operand [95:64]
  input  logic [ccfu_pkg::IN_TDATA_W-1:0]      in_tdata,
  // op [2:0], size [4:3]
  input  logic [ccfu_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // flag_x [0], flag_n [1], flag_z [2], flag_v [3], flag_c [4], zero [7:5]
  output logic [ccfu_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import ccfu_pkg::*;

  logic   item_valid;
  item_t  item;
  logic   adv;
  flags_t flags_r;
  flags_t flags_nxt;
  logic   out_v_r;

  ccfu_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  ccfu_flag_calc u_flag_calc (
    .item      (item),
    .flags_cur (flags_r),
    .flags_nxt (flags_nxt)
  );

  // the flag register doubles as the output word
  assign adv        = item_valid && (!out_v_r || out_tready);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W-FLAG_W){1'b0}}, flags_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        flags_r <= flags_nxt;
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !item_valid)
    else $error("stages not empty after reset");

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(flags_r))
    else $error("flags changed without an operation moving out");

  a_logic_clears_vc: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.op == OP_LOGIC |=> !flags_r.v && !flags_r.c)
    else $error("logic operation left v or c set");

  a_x_kept: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (item.op == OP_LOGIC || item.op == OP_ADD32 || item.op == OP_SUB32)
    |=> flags_r.x == $past(flags_r.x))
    else $error("x changed by an operation that keeps it");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ccfu_pkg::*;

  localparam logic [2:0] OP_NONE   = 3'd7;  // unused op code, flags hold
  localparam logic [1:0] SZ_SPARE  = 2'd3;  // unused size code, taken as long
  localparam int         CYCLE_CAP = 200000;
  localparam int         BLOCK_LEN = 62;

  typedef struct {
    logic [2:0]  op;
    logic [1:0]  sz;
    logic [31:0] r;
    logic [31:0] d;
    logic [31:0] s;
    bit          chk;
    flags_t      want;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // result_value [31:0], dest_operand [63:32], source_operand [95:64]
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // op [2:0], size [4:3]
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // flag_x [0], flag_n [1], flag_z [2], flag_v [3], flag_c [4], zero [7:5]
  logic [OUT_TDATA_W-1:0] out_tdata;

  flags_t   ccr_now;
  flags_t   flags_due[$];
  dir_row_t dir_rows[$];
  int       idle_pct      = 0;
  int       stall_pct     = 0;
  int       fail_count    = 0;
  int       words_sent    = 0;
  int       words_checked = 0;
  int       cycles        = 0;
  int       op_cnt[8];

  condition_code_flag_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d flag words outstanding", cycles, flags_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic flags_t fl(bit x, bit n, bit z, bit v, bit c);
    flags_t f;
    f.x = x;
    f.n = n;
    f.z = z;
    f.v = v;
    f.c = c;
    return f;
  endfunction

  // flags after one operation word, starting from cur
  function automatic flags_t next_flags(flags_t cur, logic [2:0] op, logic [1:0] sz,
                                        logic [31:0] r, logic [31:0] d, logic [31:0] s);
    logic [31:0] m;
    logic [31:0] top;
    logic        sub_op;
    logic        ext_op;
    logic        zero;
    logic        cy;
    logic        ov;
    flags_t      f;
    f = cur;
    if (op == OP_NONE) return f;
    if (op == OP_ADD32 || op == OP_SUB32 || sz == SZ_SPARE) sz = SZ_LONG;
    case (sz)
      SZ_BYTE: begin
        m   = 32'h0000_00FF;
        top = 32'h0000_0080;
      end
      SZ_WORD: begin
        m   = 32'h0000_FFFF;
        top = 32'h0000_8000;
      end
      default: begin
        m   = 32'hFFFF_FFFF;
        top = 32'h8000_0000;
      end
    endcase
    r      = r & m;
    d      = d & m;
    s      = s & m;
    sub_op = (op == OP_SUB32 || op == OP_SUBX || op == OP_SUB);
    ext_op = (op == OP_ADDX || op == OP_SUBX);
    zero   = (r == 32'h0);
    if (op == OP_LOGIC) begin
      cy = 1'b0;
      ov = 1'b0;
    end else if (sub_op) begin
      cy = |(((s & ~d) | (r & ~d) | (s & r)) & top);
      ov = |(((s ^ d) & (r ^ d)) & top);
    end else begin
      cy = |(((s & d) | (~r & (s | d))) & top);
      ov = |((~(s ^ d) & (r ^ d)) & top);
    end
    // the extended forms can only clear z, so multi-precision chains keep it
    if (!ext_op) f.z = zero;
    else if (!zero) f.z = 1'b0;
    f.n = |(r & top);
    f.v = ov;
    f.c = cy;
    if (op >= OP_ADD) f.x = cy;
    return f;
  endfunction

  task automatic report_fail(string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic cmp_flag(string name, logic got, logic want);
    if (got !== want)
      report_fail($sformatf("flag %s got %b want %b on result %0d",
                            name, got, want, words_checked));
  endtask

  always @(posedge clk) begin : result_mon
    flags_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (flags_due.size() == 0) begin
        report_fail($sformatf("flag word %b with nothing outstanding", out_tdata));
      end else begin
        want = flags_due.pop_front();
        cmp_flag("x", out_tdata[0], want.x);
        cmp_flag("n", out_tdata[1], want.n);
        cmp_flag("z", out_tdata[2], want.z);
        cmp_flag("v", out_tdata[3], want.v);
        cmp_flag("c", out_tdata[4], want.c);
        if (out_tdata[7:5] !== 3'b000)
          report_fail($sformatf("padding bits %b on result %0d", out_tdata[7:5], words_checked));
      end
      words_checked++;
    end
  end

  task automatic send_word(input logic [2:0] op, input logic [1:0] sz, input logic [31:0] r,
                           input logic [31:0] d, input logic [31:0] s,
                           input bit chk, input flags_t want);
    flags_t nxt;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {sz, op};
    in_tdata  <= {s, d, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    nxt     = next_flags(ccr_now, op, sz, r, d, s);
    ccr_now = nxt;
    flags_due.push_back(chk ? want : nxt);
    op_cnt[op]++;
    words_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (flags_due.size() != 0);
  endtask

  // operands lean towards the sign boundaries of each size
  function automatic logic [31:0] pick_operand();
    logic [31:0] top;
    int          sel;
    sel = $urandom_range(0, 2);
    top = 32'h80 << (8 * ((sel == 2) ? 3 : sel));
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return top;
      3:       return top - 1;
      4:       return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random();
    logic [2:0]  op;
    logic [1:0]  sz;
    logic [31:0] d;
    logic [31:0] s;
    logic [31:0] r;
    logic [31:0] cin;
    op  = ($urandom_range(0, 99) < 3) ? OP_NONE : 3'($urandom_range(0, 6));
    sz  = ($urandom_range(0, 99) < 5) ? SZ_SPARE : 2'($urandom_range(0, 2));
    d   = pick_operand();
    s   = pick_operand();
    cin = (op == OP_ADDX || op == OP_SUBX) ? 32'(ccr_now.x) : 32'h0;
    case (op)
      OP_LOGIC: begin
        case ($urandom_range(0, 3))
          0:       r = d & s;
          1:       r = d | s;
          2:       r = d ^ s;
          default: r = ~d;
        endcase
      end
      OP_ADD32, OP_ADD, OP_ADDX: r = d + s + cin;
      OP_SUB32, OP_SUB, OP_SUBX: r = d - s - cin;
      default:                   r = $urandom;
    endcase
    // some noise: a result that does not follow from the operands
    if ($urandom_range(0, 99) < 10) r = pick_operand();
    send_word(op, sz, r, d, s, 1'b0, fl(0, 0, 0, 0, 0));
  endtask

  initial begin
    foreach (op_cnt[i]) op_cnt[i] = 0;
    ccr_now = fl(0, 0, 0, 0, 0);

    //                                 op        size      result         dest           source
    dir_rows.push_back(dir_row_t'{OP_LOGIC, SZ_BYTE,  32'h0000_0000, 32'h0,         32'h0,
                                  1'b1, fl(0, 0, 1, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_LOGIC, SZ_LONG,  32'h8000_0000, 32'h0,         32'h0,
                                  1'b1, fl(0, 1, 0, 0, 0)});
    // high bits beyond the byte must be masked off
    dir_rows.push_back(dir_row_t'{OP_LOGIC, SZ_BYTE,  32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  1'b1, fl(0, 0, 1, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_LOGIC, SZ_WORD,  32'h0000_8000, 32'h0,         32'h0,
                                  1'b1, fl(0, 1, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_ADD,   SZ_BYTE,  32'h0000_0000, 32'h0000_00FF, 32'h0000_0001,
                                  1'b1, fl(1, 0, 1, 0, 1)});
    dir_rows.push_back(dir_row_t'{OP_ADD,   SZ_BYTE,  32'h0000_0080, 32'h0000_007F, 32'h0000_0001,
                                  1'b1, fl(0, 1, 0, 1, 0)});
    dir_rows.push_back(dir_row_t'{OP_SUB,   SZ_BYTE,  32'h0000_00FF, 32'h0000_0000, 32'h0000_0001,
                                  1'b1, fl(1, 1, 0, 0, 1)});
    dir_rows.push_back(dir_row_t'{OP_SUB,   SZ_WORD,  32'h0000_7FFF, 32'h0000_8000, 32'h0000_0001,
                                  1'b1, fl(0, 0, 0, 1, 0)});
    // 32-bit forms ignore size and leave x alone
    dir_rows.push_back(dir_row_t'{OP_ADD32, SZ_BYTE,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                  1'b1, fl(0, 0, 1, 0, 1)});
    dir_rows.push_back(dir_row_t'{OP_SUB32, SZ_WORD,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                  1'b1, fl(0, 0, 0, 1, 0)});
    dir_rows.push_back(dir_row_t'{OP_ADD,   SZ_LONG,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                  1'b1, fl(1, 0, 1, 0, 1)});
    dir_rows.push_back(dir_row_t'{OP_SUB32, SZ_LONG,  32'h0000_0002, 32'h0000_0005, 32'h0000_0003,
                                  1'b1, fl(1, 0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_LOGIC, SZ_LONG,  32'h0000_0000, 32'h0,         32'h0,
                                  1'b1, fl(1, 0, 1, 0, 0)});
    // extended forms: zero result keeps z, non-zero clears it
    dir_rows.push_back(dir_row_t'{OP_ADDX,  SZ_BYTE,  32'h0000_0000, 32'h0,         32'h0,
                                  1'b1, fl(0, 0, 1, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_ADDX,  SZ_BYTE,  32'h0000_0001, 32'h0,         32'h0,
                                  1'b1, fl(0, 0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_ADDX,  SZ_BYTE,  32'h0000_0000, 32'h0000_00FF, 32'h0,
                                  1'b1, fl(1, 0, 0, 0, 1)});
    dir_rows.push_back(dir_row_t'{OP_SUBX,  SZ_WORD,  32'h0000_0000, 32'h0,         32'h0,
                                  1'b1, fl(0, 0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_SUBX,  SZ_LONG,  32'h0000_0000, 32'h0,         32'hFFFF_FFFF,
                                  1'b1, fl(1, 0, 0, 0, 1)});
    // unused size code behaves as long
    dir_rows.push_back(dir_row_t'{OP_ADD,   SZ_SPARE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                                  1'b1, fl(0, 1, 0, 1, 0)});
    // unused op code re-emits the flags unchanged
    dir_rows.push_back(dir_row_t'{OP_NONE,  SZ_BYTE,  32'h0000_0000, 32'h0,         32'h0,
                                  1'b1, fl(0, 1, 0, 1, 0)});
    dir_rows.push_back(dir_row_t'{OP_NONE,  SZ_LONG,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  1'b1, fl(0, 1, 0, 1, 0)});
    dir_rows.push_back(dir_row_t'{OP_SUB,   SZ_LONG,  32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  1'b1, fl(0, 0, 1, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_ADD,   SZ_WORD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  1'b1, fl(1, 1, 0, 0, 1)});
    dir_rows.push_back(dir_row_t'{OP_SUB,   SZ_BYTE,  32'h0000_005A, 32'h0000_00A5, 32'h0000_004B,
                                  1'b0, fl(0, 0, 0, 0, 0)});
    dir_rows.push_back(dir_row_t'{OP_ADDX,  SZ_WORD,  32'hDEAD_1234, 32'h0000_FFFF, 32'h1234_1235,
                                  1'b0, fl(0, 0, 0, 0, 0)});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].sz, dir_rows[i].r, dir_rows[i].d, dir_rows[i].s,
                dir_rows[i].chk, dir_rows[i].want);
    wait_drained();

    // idling schedule: none, sender idle, receiver stalling, both, twice over
    for (int blk = 0; blk < 8; blk++) begin
      case (blk % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
        end
        default: begin
          idle_pct  = 19;
          stall_pct = 19;
        end
      endcase
      repeat (BLOCK_LEN) send_random();
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("sent %0d operation words (%0d directed), checked %0d flag words, %0d mismatches",
             words_sent, dir_rows.size(), words_checked, fail_count);
    $display("per op: logic %0d add32 %0d sub32 %0d add %0d addx %0d subx %0d sub %0d unused %0d",
             op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3], op_cnt[4], op_cnt[5], op_cnt[6],
             op_cnt[7]);
    if (fail_count == 0 && flags_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
